// ===== hw/rtl/splis_pkg.sv =====
`default_nettype none
package splis_pkg;

  // fixed field widths
  localparam int VALUE_W = 31;
  localparam int SHIFT_W = 30;
  localparam int BEST_W = 11;
  // key: negated value plus shift
  localparam int KEY_W = 33;
  // stored tail width: a negated value
  localparam int TAIL_W = 32;

  localparam int MAX_ELEMENTS_DEFAULT = 1024;
  localparam logic [BEST_W-1:0] BEST_SAT = '1;

  // command to the tails unit
  typedef struct packed {
    logic start;
    logic ins;
    logic clr;
  } tails_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/shifted_prefix_lis_length.sv =====
`default_nettype none
// Longest strictly increasing subsequence with a shifted prefix bound.
// Input channel (in_valid/in_ready): sample_value and is_last. Values are
// taken one per cycle while loading; up to MaxElements are kept, later ones
// are dropped. The transfer with is_last set starts evaluation.
// Evaluation runs two passes, each a forward and a backward sweep over the
// stored values against a tails memory searched by bisection, with at most
// L = clog2(MaxElements+1) probes per search. In the first sweep of a pass
// an element takes a bound search, then a search and insert; in the second
// sweep it takes only a search and insert.
// Output channel (out_valid/out_ready): best_length, held in an output
// register. Loading of the next sequence may start while a result waits;
// a finished evaluation holds until the output register is free.
// cfg_write/cfg_data set shift_amount; the user must write it only while idle, the block does not enforce this.
// Reset (rst, synchronous) empties the sequence, clears the shift to zero
// and drops any pending result.
module shifted_prefix_lis_length #(
  parameter int MaxElements = splis_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  [splis_pkg::SHIFT_W-1:0]  cfg_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [splis_pkg::VALUE_W-1:0]  sample_value,
  input  wire                            is_last,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [splis_pkg::BEST_W-1:0]   best_length
);

  localparam int AW = $clog2(MaxElements);
  localparam int CW = $clog2(MaxElements + 1);
  localparam int BW = CW + 1;
  localparam int WW = BW + splis_pkg::BEST_W;
  localparam logic [CW-1:0] MAX_C = CW'(MaxElements);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PH   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_GET  = 3'd3;
  localparam logic [2:0] S_W1   = 3'd4;
  localparam logic [2:0] S_W2   = 3'd5;
  localparam logic [2:0] S_W3   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [splis_pkg::SHIFT_W-1:0] shift_amount;
  logic [CW-1:0] elem_count;
  logic [BW-1:0] best;
  logic [AW-1:0] idx;
  logic pass_r;
  logic half_r;

  logic [splis_pkg::VALUE_W-1:0] seq_mem [MaxElements];
  logic [splis_pkg::VALUE_W-1:0] seq_rd;
  logic [CW-1:0] pre_mem [MaxElements];
  logic [CW-1:0] pre_rd;

  splis_pkg::tails_cmd_t cmd;
  logic [splis_pkg::KEY_W-1:0] key;
  logic t_done;
  logic [CW-1:0] t_count;

  logic in_fire;
  logic neg;
  logic up;
  logic [splis_pkg::TAIL_W-1:0] val;
  logic [splis_pkg::KEY_W-1:0] bound;
  logic [BW-1:0] sum;
  logic [CW-1:0] last_pos;
  logic at_end;
  logic [WW-1:0] best_wide;

  assign in_ready = (state == S_LOAD);
  assign in_fire = in_valid && in_ready;
  assign neg = pass_r ^ half_r;
  assign up = !neg;
  assign last_pos = elem_count - CW'(1);
  assign at_end = up ? (CW'(idx) == last_pos) : (idx == '0);
  assign best_wide = WW'(best);

  // element value, negated in backward sweeps
  always_comb begin
    val = {seq_rd[splis_pkg::VALUE_W-1], seq_rd};
    if (neg) begin
      val = -val;
    end
    bound = {val[splis_pkg::TAIL_W-1], val} + splis_pkg::KEY_W'(shift_amount);
    sum = BW'(t_count) + BW'(1) + BW'(pre_rd);
  end

  // commands to the tails unit
  always_comb begin
    cmd = '0;
    key = bound;
    case (state)
      S_PH: cmd.clr = 1'b1;
      S_GET: begin
        cmd.start = 1'b1;
        cmd.ins = half_r;
        key = half_r ? {val[splis_pkg::TAIL_W-1], val} : bound;
      end
      S_W1: begin
        cmd.start = t_done;
        cmd.ins = 1'b1;
        key = {val[splis_pkg::TAIL_W-1], val};
      end
      default: cmd = '0;
    endcase
  end

  splis_tails #(.MaxElements(MaxElements)) u_tails (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .key(key),
    .done(t_done),
    .count(t_count)
  );

  // sequence and prefix-length memories
  always_ff @(posedge clk) begin
    if (in_fire && (elem_count < MAX_C)) begin
      seq_mem[elem_count[AW-1:0]] <= sample_value;
    end
    if ((state == S_W1) && t_done) begin
      pre_mem[idx] <= t_count;
    end
    seq_rd <= seq_mem[idx];
    pre_rd <= pre_mem[idx];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= '0;
    end else if (cfg_write) begin
      shift_amount <= cfg_data;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      elem_count <= '0;
      best <= '0;
      pass_r <= 1'b0;
      half_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (elem_count < MAX_C) begin
              elem_count <= elem_count + CW'(1);
            end
            if (is_last) begin
              pass_r <= 1'b0;
              half_r <= 1'b0;
              best <= '0;
              state <= S_PH;
            end
          end
        end
        S_PH: begin
          idx <= up ? '0 : last_pos[AW-1:0];
          state <= S_RD;
        end
        S_RD: state <= S_GET;
        S_GET: state <= half_r ? S_W3 : S_W1;
        S_W1: begin
          if (t_done) begin
            state <= S_W2;
          end
        end
        S_W2, S_W3: begin
          if (t_done) begin
            if ((state == S_W3) && (sum > best)) begin
              best <= sum;
            end
            if (!at_end) begin
              idx <= up ? idx + AW'(1) : idx - AW'(1);
              state <= S_RD;
            end else if (!half_r) begin
              half_r <= 1'b1;
              state <= S_PH;
            end else if (!pass_r) begin
              pass_r <= 1'b1;
              half_r <= 1'b0;
              state <= S_PH;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            best_length <= (best_wide > WW'(splis_pkg::BEST_SAT)) ?
                           splis_pkg::BEST_SAT : best_wide[splis_pkg::BEST_W-1:0];
            elem_count <= '0;
            best <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= MAX_C) else $error("element count beyond capacity");

  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_last |=> !in_ready) else $error("loading continued after last");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result without evaluation");

endmodule
`default_nettype wire

// ===== hw/rtl/splis_tails.sv =====
`default_nettype none
module splis_tails #(
  parameter int MaxElements = splis_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  splis_pkg::tails_cmd_t          cmd,
  input  wire  [splis_pkg::KEY_W-1:0]    key,
  output logic                           done,
  output logic [$clog2(MaxElements+1)-1:0] count
);

  localparam int AW = $clog2(MaxElements);
  localparam int CW = $clog2(MaxElements + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MaxElements);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_STEP = 2'd1;
  localparam logic [1:0] T_CMP  = 2'd2;

  logic [1:0] state;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] len;
  logic [splis_pkg::KEY_W-1:0] key_r;
  logic ins_r;

  // tails memory, entry k+1 of the table lives at address k
  logic [splis_pkg::TAIL_W-1:0] mem [MaxElements];
  logic [splis_pkg::TAIL_W-1:0] rdata;

  logic [CW-1:0] mid;
  logic          searching;
  logic          we;
  logic          less;

  assign mid = lo + ((hi - lo) >> 1);
  assign searching = (lo < hi);
  assign we = (state == T_STEP) && !searching && ins_r && ((lo != len) || (len < MAX_C));
  assign less = $signed({rdata[splis_pkg::TAIL_W-1], rdata}) < $signed(key_r);
  assign count = lo;

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[lo[AW-1:0]] <= key_r[splis_pkg::TAIL_W-1:0];
    end
    rdata <= mem[mid[AW-1:0]];
  end

  // binary search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      len <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == T_STEP) && !searching;
      case (state)
        T_IDLE: begin
          if (cmd.clr) begin
            len <= '0;
          end
          if (cmd.start) begin
            lo <= '0;
            hi <= len;
            key_r <= key;
            ins_r <= cmd.ins;
            state <= T_STEP;
          end
        end
        T_STEP: begin
          if (searching) begin
            state <= T_CMP;
          end else begin
            state <= T_IDLE;
            if (ins_r && (lo == len) && (len < MAX_C)) begin
              len <= len + CW'(1);
            end
          end
        end
        T_CMP: begin
          if (less) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= T_STEP;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
